/* design/timed_action_queue_executor_defines.svh */
// Assertion macros for the timed action queue executor.
`ifndef TIMED_ACTION_QUEUE_EXECUTOR_DEFINES_SVH
`define TIMED_ACTION_QUEUE_EXECUTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TAQE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TAQE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/taqe_pkg.sv */
// Shared types and constants of the timed action queue executor.
package taqe_pkg;

    localparam int CODE_W   = 4;
    localparam int DATA_W   = 8;
    localparam int PERIOD_W = 16;

    localparam logic [PERIOD_W-1:0] INIT_PERIOD = 16'd1600;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [1:0] SEL_NONE = 2'b00;
    localparam logic [1:0] SEL_X    = 2'b01;
    localparam logic [1:0] SEL_Y    = 2'b10;

    typedef enum logic [CODE_W-1:0] {
        ACT_WAIT         = 4'd0,
        ACT_X_START      = 4'd1,
        ACT_Y_START      = 4'd2,
        ACT_DATA         = 4'd3,
        ACT_END          = 4'd4,
        ACT_LASER        = 4'd5,
        ACT_PERIOD_HI    = 4'd6,
        ACT_PERIOD_LO    = 4'd7,
        ACT_PERIOD_SHORT = 4'd8
    } t_action;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
        logic one_left;
    } t_ring_stat;

    typedef struct packed {
        logic                spi_valid;
        logic [DATA_W-1:0]   spi_byte;
        logic                select_x_line;
        logic                select_y_line;
        logic                laser_enable;
        logic [PERIOD_W-1:0] tick_period;
        logic                enqueue_dropped;
        logic                last;
    } t_out_beat;

endpackage

/* design/taqe_in_if.sv */
// Input channel: enqueue and tick beats.
interface taqe_in_if import taqe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [CODE_W-1:0] action_code;
    logic [DATA_W-1:0] action_data;

    modport source (output valid, operation, action_code, action_data, input ready);
    modport sink   (input valid, operation, action_code, action_data, output ready);
endinterface

/* design/taqe_out_if.sv */
// Output channel: one beat per executed action or per input beat.
interface taqe_out_if import taqe_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                spi_valid;
    logic [DATA_W-1:0]   spi_byte;
    logic                select_x_line;
    logic                select_y_line;
    logic                laser_enable;
    logic [PERIOD_W-1:0] tick_period;
    logic                enqueue_dropped;
    logic                last;

    modport source (output valid, spi_valid, spi_byte, select_x_line, select_y_line,
                    laser_enable, tick_period, enqueue_dropped, last, input ready);
    modport sink   (input valid, spi_valid, spi_byte, select_x_line, select_y_line,
                    laser_enable, tick_period, enqueue_dropped, last, output ready);
endinterface

/* design/taqe_ring.sv */
// Ring queue of action words: storage memory, pointers and fill count.
module taqe_ring import taqe_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ring_ctrl        i_ctrl,
    input  logic [CODE_W-1:0] i_wr_code,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic [CODE_W-1:0] o_rd_code,
    output logic [DATA_W-1:0] o_rd_data,
    output t_ring_stat        o_stat
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = CODE_W + DATA_W;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_word;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_rd_ptr = i_ctrl.pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_wr_ptr = i_ctrl.push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_count  = r_count;
        if (i_ctrl.push) begin
            n_count = r_count + 1'b1;
        end else if (i_ctrl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    // Registered read at the next head pointer so the word is ready when needed.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_wr_ptr] <= {i_wr_code, i_wr_data};
        end
        r_rd_word <= r_mem[n_rd_ptr];
    end

    assign o_rd_code       = r_rd_word[WORD_W-1:DATA_W];
    assign o_rd_data       = r_rd_word[DATA_W-1:0];
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CNT_W'(DEPTH));
    assign o_stat.one_left = (r_count == CNT_W'(1));

endmodule

/* design/timed_action_queue_executor.sv */
// Timed action queue executor: top level with tick sequencer and output register.
//
// i_in carries beats of operation, action_code and action_data. An enqueue
// beat stores one action word in the ring and yields one output beat with
// last set; enqueue_dropped is set when the ring was full. A tick beat pops
// and runs actions in order until a wait (or unknown code) has been popped
// or the ring runs empty, one output beat per popped action, last on the
// final one; a tick on an empty ring yields one idle beat.
// Enqueue and empty ticks: the result is registered on acceptance.
// Ticks with work: after acceptance, S_EXEC decodes each action into the output
// register; one per cycle unless stalled, bounded by the single ring read port.
// A new input beat is taken once the previous beat's run is done and the
// output register is empty or being read in that cycle.
// Output stalls hold the output register and pause the sequencer.
// i_cfg_wr_en with i_cfg_wr_data loads the tick period directly.
// Reset: empty ring, both selects high, laser off, period 1600.
`include "timed_action_queue_executor_defines.svh"
module timed_action_queue_executor import taqe_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    taqe_in_if.sink             i_in,
    taqe_out_if.source          o_out,
    input  logic                i_cfg_wr_en,
    input  logic [PERIOD_W-1:0] i_cfg_wr_data
);

    t_state              r_state, n_state;
    t_ring_ctrl          ring_ctrl;
    t_ring_stat          ring_stat;
    logic [CODE_W-1:0]   rd_code;
    logic [DATA_W-1:0]   rd_data;

    t_out_beat           r_out, n_out;
    logic                r_out_valid;
    logic                load_out;
    logic                out_free;
    logic                in_fire;

    logic [1:0]          r_active, n_active;
    logic [1:0]          r_sel, n_sel;
    logic                r_laser, n_laser;
    logic [DATA_W-1:0]   r_hold, n_hold;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic                stop;

    taqe_ring #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ring_ctrl),
        .i_wr_code (i_in.action_code),
        .i_wr_data (i_in.action_data),
        .o_rd_code (rd_code),
        .o_rd_data (rd_data),
        .o_stat    (ring_stat)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign in_fire    = i_in.valid && i_in.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_in.operation == OP_TICK) && !ring_stat.empty) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free && (stop || ring_stat.one_left)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Action decode and result
    always_comb begin
        n_active  = r_active;
        n_sel     = r_sel;
        n_laser   = r_laser;
        n_hold    = r_hold;
        n_period  = r_period;
        stop      = 1'b0;
        ring_ctrl = '0;
        load_out  = 1'b0;
        n_out     = '0;

        unique case (rd_code)
            ACT_X_START: begin
                n_active = SEL_X;
                n_sel    = r_sel & ~SEL_X;
                n_out.spi_valid = 1'b1;
                n_out.spi_byte  = rd_data;
            end
            ACT_Y_START: begin
                n_active = SEL_Y;
                n_sel    = r_sel & ~SEL_Y;
                n_out.spi_valid = 1'b1;
                n_out.spi_byte  = rd_data;
            end
            ACT_DATA: begin
                n_out.spi_valid = 1'b1;
                n_out.spi_byte  = rd_data;
            end
            ACT_END:          n_sel    = r_sel | r_active;
            ACT_LASER:        n_laser  = (rd_data != '0);
            ACT_PERIOD_HI:    n_hold   = rd_data;
            ACT_PERIOD_LO:    n_period = {r_hold, rd_data};
            ACT_PERIOD_SHORT: n_period = PERIOD_W'(rd_data);
            default:          stop     = 1'b1;
        endcase

        unique case (r_state)
            S_IDLE: begin
                n_active = r_active;
                n_sel    = r_sel;
                n_laser  = r_laser;
                n_hold   = r_hold;
                n_period = r_period;
                n_out    = '0;
                if (in_fire) begin
                    if (i_in.operation == OP_ENQUEUE) begin
                        ring_ctrl.push        = !ring_stat.full;
                        n_out.enqueue_dropped = ring_stat.full;
                        n_out.last            = 1'b1;
                        load_out              = 1'b1;
                    end else if (ring_stat.empty) begin
                        n_out.last = 1'b1;
                        load_out   = 1'b1;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    ring_ctrl.pop = 1'b1;
                    n_out.last    = stop || ring_stat.one_left;
                    load_out      = 1'b1;
                end else begin
                    n_active = r_active;
                    n_sel    = r_sel;
                    n_laser  = r_laser;
                    n_hold   = r_hold;
                    n_period = r_period;
                end
            end
            default: ;
        endcase

        n_out.select_x_line = n_sel[0];
        n_out.select_y_line = n_sel[1];
        n_out.laser_enable  = n_laser;
        n_out.tick_period   = n_period;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= SEL_NONE;
            r_sel       <= SEL_X | SEL_Y;
            r_laser     <= 1'b0;
            r_hold      <= '0;
            r_period    <= INIT_PERIOD;
        end else begin
            r_state     <= n_state;
            r_out_valid <= load_out || (r_out_valid && !o_out.ready);
            r_active    <= n_active;
            r_sel       <= n_sel;
            r_laser     <= n_laser;
            r_hold      <= n_hold;
            r_period    <= i_cfg_wr_en ? i_cfg_wr_data : n_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.spi_valid       = r_out.spi_valid;
    assign o_out.spi_byte        = r_out.spi_byte;
    assign o_out.select_x_line   = r_out.select_x_line;
    assign o_out.select_y_line   = r_out.select_y_line;
    assign o_out.laser_enable    = r_out.laser_enable;
    assign o_out.tick_period     = r_out.tick_period;
    assign o_out.enqueue_dropped = r_out.enqueue_dropped;
    assign o_out.last            = r_out.last;

    `TAQE_ASSERT_NOW(a_exec_not_empty, i_clk, i_rst_n, r_state == S_EXEC, !ring_stat.empty, "sequencer running on an empty ring")
    `TAQE_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, ring_ctrl.push, !ring_stat.empty, "ring empty after a push")
    `TAQE_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, load_out && n_out.last, r_state == S_IDLE, "run continued past its last beat")
    `TAQE_ASSERT_NOW(a_byte_not_dropped, i_clk, i_rst_n, r_out_valid && r_out.spi_valid, !r_out.enqueue_dropped, "byte beat flagged as dropped")

endmodule
